/* rtl/core/binned_robust_averager_assert.svh */
// Assertion macros for the binned robust averager.
// Depends on a clock named clk and an active-low reset named arst_n in the including scope.
`ifndef BINNED_ROBUST_AVERAGER_ASSERT_SVH
`define BINNED_ROBUST_AVERAGER_ASSERT_SVH
`ifndef ASSERT_OFF
// A condition that must hold at every clock edge outside reset.
`define BRA_ASSERT(lbl, cond, msg) lbl: assert property (@(posedge clk) disable iff (!arst_n) \
	(cond)) else $error(msg);
// A condition that must hold whenever its antecedent holds.
`define BRA_IMPLY(lbl, ante, cons, msg) lbl: assert property (@(posedge clk) \
	disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`else
`define BRA_ASSERT(lbl, cond, msg)
`define BRA_IMPLY(lbl, ante, cons, msg)
`endif
`endif

/* rtl/core/bra_pkg.sv */
// Shared types, constants and helpers of the binned robust averager.
// No dependencies; the front, queue, back and top files of the block import this package.
package bra_pkg;

	// Grid and bin geometry, given as powers of two.
	localparam int X_W = 1;
	localparam int Y_W = 4;
	localparam int Z_W = 10;
	localparam int DEPTH_LOG = 4;
	localparam int BIN_DEPTH = 1 << DEPTH_LOG;
	localparam int BIN_W = X_W + Y_W + Z_W;
	localparam int NUM_BINS = 1 << BIN_W;
	localparam int ADDR_W = BIN_W + DEPTH_LOG;
	localparam int IDX_W = DEPTH_LOG;
	localparam int CNT_W = DEPTH_LOG + 1;
	localparam int SMP_W = 24;
	localparam int SUM_W = SMP_W + DEPTH_LOG;
	localparam int STEP_W = $clog2(SUM_W);

	// Queue between the front and the back.
	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	// Window constants of the median and the robust mean.
	localparam int MEDIAN_DIV = 2;
	localparam int ROBUST_DIV = 4;
	localparam int ROBUST_MUL = 3;

	localparam logic signed [SMP_W-1:0] SMP_MAX = {1'b0, {(SMP_W-1){1'b1}}};

	// Command codes.
	localparam logic [2:0] CMD_ADD = 3'd0;
	localparam logic [2:0] CMD_MEAN = 3'd1;
	localparam logic [2:0] CMD_MEDIAN = 3'd2;
	localparam logic [2:0] CMD_ROBUST = 3'd3;
	localparam logic [2:0] CMD_CLEAR = 3'd4;

	// Status codes.
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [2:0] cmd;
		logic bin_x;
		logic [3:0] bin_y;
		logic [9:0] bin_z;
		logic signed [23:0] sample_value;
	} req_t;

	typedef struct packed {
		logic signed [23:0] result_value;
		logic [4:0] sample_count;
		logic [1:0] status;
	} rsp_t;

	// One classified command as it travels from the front to the back.
	typedef struct packed {
		logic [2:0] cmd;
		logic [BIN_W-1:0] bin;
		logic [CNT_W-1:0] n;
		logic [1:0] status;
		logic signed [SMP_W-1:0] sample;
	} op_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// Wrap each coordinate to its grid dimension and form the flat bin index.
	function automatic logic [BIN_W-1:0] bin_index(input logic x, input logic [3:0] y,
			input logic [9:0] z);
		logic [31:0] xs;
		logic [31:0] ys;
		logic [31:0] zs;
		xs = 32'(x) & ((32'd1 << X_W) - 32'd1);
		ys = 32'(y) & ((32'd1 << Y_W) - 32'd1);
		zs = 32'(z) & ((32'd1 << Z_W) - 32'd1);
		return BIN_W'((xs << (Y_W + Z_W)) | (ys << Z_W) | zs);
	endfunction

endpackage

/* rtl/core/bra_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module bra_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/core/bra_front.sv */
// Front part: accepts commands, keeps the per-bin counts and classifies each command.
// Depends on bra_pkg and bra_ram.
module bra_front (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_ready,
	input bra_pkg::req_t req,
	output logic q_push,
	output bra_pkg::op_t q_op,
	input bra_pkg::q_stat_t q_stat
);
	import bra_pkg::*;

	localparam logic [2:0] F_CLEAR = 3'd0;
	localparam logic [2:0] F_IDLE = 3'd1;
	localparam logic [2:0] F_READ = 3'd2;
	localparam logic [2:0] F_DECIDE = 3'd3;
	localparam logic [2:0] F_PUSH = 3'd4;

	logic [2:0] state_q;
	logic [BIN_W-1:0] sweep_q;
	logic clr_cmd_q;
	req_t req_q;
	logic [BIN_W-1:0] bin_q;
	op_t op_q;

	logic cnt_we;
	logic [BIN_W-1:0] cnt_waddr;
	logic [CNT_W-1:0] cnt_wdata;
	logic cnt_re;
	logic [CNT_W-1:0] cnt_rdata;
	logic [CNT_W-1:0] n_rd;
	op_t dec_op;
	logic dec_wr;

	// Count store; a sweep clears it after reset and on a clear command.
	bra_ram #(
		.WIDTH(CNT_W),
		.DEPTH(NUM_BINS)
	) u_cnt_ram (
		.clk(clk),
		.we(cnt_we),
		.waddr(cnt_waddr),
		.wdata(cnt_wdata),
		.re(cnt_re),
		.raddr(bin_q),
		.rdata(cnt_rdata)
	);

	// Classify the command against the count that was read.
	always_comb begin
		n_rd = (cnt_rdata > CNT_W'(BIN_DEPTH)) ? CNT_W'(BIN_DEPTH) : cnt_rdata;
		dec_op.cmd = req_q.cmd;
		dec_op.bin = bin_q;
		dec_op.n = n_rd;
		dec_op.status = ST_OK;
		dec_op.sample = req_q.sample_value;
		dec_wr = 1'b0;
		case (req_q.cmd)
			CMD_ADD: begin
				if (n_rd >= CNT_W'(BIN_DEPTH)) begin
					dec_op.status = ST_FULL;
				end else begin
					dec_op.n = n_rd + 1'b1;
					dec_wr = 1'b1;
				end
			end
			CMD_MEAN, CMD_MEDIAN: begin
				if (n_rd == '0) begin
					dec_op.status = ST_EMPTY;
				end
			end
			CMD_ROBUST: begin
				if ((n_rd / ROBUST_DIV) == '0) begin
					dec_op.status = ST_EMPTY;
				end
			end
			default: begin
			end
		endcase
	end

	// Count store ports.
	assign cnt_we = (state_q == F_CLEAR) || ((state_q == F_DECIDE) && dec_wr);
	assign cnt_waddr = (state_q == F_CLEAR) ? sweep_q : bin_q;
	assign cnt_wdata = (state_q == F_CLEAR) ? '0 : dec_op.n;
	assign cnt_re = (state_q == F_READ);

	assign req_ready = (state_q == F_IDLE);
	assign q_push = (state_q == F_PUSH) && !q_stat.full;
	assign q_op = op_q;

	// Control sequence.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_CLEAR;
			sweep_q <= '0;
			clr_cmd_q <= 1'b0;
		end else begin
			case (state_q)
				F_CLEAR: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == '1) begin
						state_q <= clr_cmd_q ? F_PUSH : F_IDLE;
					end
				end
				F_IDLE: begin
					if (req_valid) begin
						if (req.cmd == CMD_CLEAR) begin
							sweep_q <= '0;
							clr_cmd_q <= 1'b1;
							state_q <= F_CLEAR;
						end else begin
							state_q <= F_READ;
						end
					end
				end
				F_READ: begin
					state_q <= F_DECIDE;
				end
				F_DECIDE: begin
					state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (!q_stat.full) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	// Command payload.
	always_ff @(posedge clk) begin
		if ((state_q == F_IDLE) && req_valid) begin
			req_q <= req;
			bin_q <= bin_index(req.bin_x, req.bin_y, req.bin_z);
			op_q.cmd <= req.cmd;
			op_q.bin <= bin_index(req.bin_x, req.bin_y, req.bin_z);
			op_q.n <= '0;
			op_q.status <= ST_OK;
			op_q.sample <= req.sample_value;
		end else if (state_q == F_DECIDE) begin
			op_q <= dec_op;
		end
	end

endmodule

/* rtl/core/bra_queue.sv */
// Short queue of classified commands between the front and the back.
// Depends on bra_pkg.
module bra_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input bra_pkg::op_t op_in,
	input logic pop,
	output bra_pkg::op_t op_out,
	output bra_pkg::q_stat_t stat
);
	import bra_pkg::*;

	op_t entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign stat.full = (cnt_q == QCNT_W'(QDEPTH));
	assign stat.empty = (cnt_q == '0);
	assign op_out = entry_q[rd_ptr_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= op_in;
		end
	end

endmodule

/* rtl/core/bra_back.sv */
// Back part: stores samples, loads and sorts a bin, sums a window and divides.
// Depends on bra_pkg and bra_ram.
module bra_back (
	input logic clk,
	input logic arst_n,
	output logic q_pop,
	input bra_pkg::op_t q_op,
	input bra_pkg::q_stat_t q_stat,
	output logic rsp_valid,
	input logic rsp_ready,
	output bra_pkg::rsp_t rsp
);
	import bra_pkg::*;

	localparam logic [3:0] B_IDLE = 4'd0;
	localparam logic [3:0] B_DISP = 4'd1;
	localparam logic [3:0] B_LOAD = 4'd2;
	localparam logic [3:0] B_SORT = 4'd3;
	localparam logic [3:0] B_PICK = 4'd4;
	localparam logic [3:0] B_SUM = 4'd5;
	localparam logic [3:0] B_ABS = 4'd6;
	localparam logic [3:0] B_DIV = 4'd7;
	localparam logic [3:0] B_SGN = 4'd8;
	localparam logic [3:0] B_DONE = 4'd9;

	logic [3:0] state_q;
	op_t op_q;
	logic [CNT_W-1:0] rd_idx_q;
	logic ld_vld_s1;
	logic [IDX_W-1:0] ld_idx_s1;
	logic signed [SMP_W-1:0] scr_q [BIN_DEPTH];
	logic signed [SMP_W-1:0] scr_nxt [BIN_DEPTH];
	logic [IDX_W-1:0] pass_q;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] hi_q;
	logic [CNT_W-1:0] div_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [SUM_W-1:0] quo_q;
	logic [CNT_W-1:0] rem_q;
	logic [STEP_W-1:0] step_q;
	logic neg_q;
	logic signed [SMP_W-1:0] res_q;
	logic rsp_valid_q;
	rsp_t rsp_q;

	logic smp_we;
	logic [ADDR_W-1:0] smp_waddr;
	logic smp_re;
	logic [ADDR_W-1:0] smp_raddr;
	logic [SMP_W-1:0] smp_rdata;
	logic signed [SMP_W-1:0] scr_rd;
	logic [CNT_W:0] rem_sh;
	logic [CNT_W-1:0] lo;
	logic is_query;

	// Sample store, BIN_DEPTH entries per bin.
	bra_ram #(
		.WIDTH(SMP_W),
		.DEPTH(1 << ADDR_W)
	) u_smp_ram (
		.clk(clk),
		.we(smp_we),
		.waddr(smp_waddr),
		.wdata(op_q.sample),
		.re(smp_re),
		.raddr(smp_raddr),
		.rdata(smp_rdata)
	);

	assign is_query = (op_q.status == ST_OK) &&
		((op_q.cmd == CMD_MEAN) || (op_q.cmd == CMD_MEDIAN) || (op_q.cmd == CMD_ROBUST));
	assign smp_we = (state_q == B_DISP) && (op_q.cmd == CMD_ADD) && (op_q.status == ST_OK);
	assign smp_waddr = {op_q.bin, IDX_W'(op_q.n - 1'b1)};
	assign smp_re = (state_q == B_LOAD) && (rd_idx_q < op_q.n);
	assign smp_raddr = {op_q.bin, rd_idx_q[IDX_W-1:0]};

	assign q_pop = (state_q == B_IDLE) && !q_stat.empty;
	assign scr_rd = scr_q[idx_q[IDX_W-1:0]];
	assign rem_sh = {rem_q, quo_q[SUM_W-1]};
	assign lo = CNT_W'(op_q.n / ROBUST_DIV);

	// One pass of odd-even transposition sorting over the scratch row.
	always_comb begin
		for (int i = 0; i < BIN_DEPTH; i++) begin
			scr_nxt[i] = scr_q[i];
		end
		for (int i = 0; i < BIN_DEPTH - 1; i++) begin
			if ((1'(i % 2) == pass_q[0]) && (scr_q[i] > scr_q[i+1])) begin
				scr_nxt[i] = scr_q[i+1];
				scr_nxt[i+1] = scr_q[i];
			end
		end
	end

	// Scratch row: filled with the maximum, loaded, then sorted.
	always_ff @(posedge clk) begin
		if ((state_q == B_DISP) && is_query) begin
			for (int i = 0; i < BIN_DEPTH; i++) begin
				scr_q[i] <= SMP_MAX;
			end
		end else if (ld_vld_s1) begin
			scr_q[ld_idx_s1] <= smp_rdata;
		end else if (state_q == B_SORT) begin
			scr_q <= scr_nxt;
		end
	end

	// Sequencer of one command.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			op_q <= '0;
			rd_idx_q <= '0;
			ld_vld_s1 <= 1'b0;
			ld_idx_s1 <= '0;
			pass_q <= '0;
			idx_q <= '0;
			hi_q <= '0;
			div_q <= '0;
			sum_q <= '0;
			quo_q <= '0;
			rem_q <= '0;
			step_q <= '0;
			neg_q <= 1'b0;
			res_q <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q <= '0;
		end else begin
			ld_vld_s1 <= smp_re;
			ld_idx_s1 <= rd_idx_q[IDX_W-1:0];
			if (rsp_valid_q && rsp_ready && (state_q != B_DONE)) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (!q_stat.empty) begin
						op_q <= q_op;
						state_q <= B_DISP;
					end
				end
				B_DISP: begin
					rd_idx_q <= '0;
					res_q <= '0;
					state_q <= is_query ? B_LOAD : B_DONE;
				end
				B_LOAD: begin
					if (rd_idx_q < op_q.n) begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end else if (!ld_vld_s1) begin
						pass_q <= '0;
						idx_q <= '0;
						hi_q <= op_q.n;
						div_q <= op_q.n;
						sum_q <= '0;
						state_q <= (op_q.cmd == CMD_MEAN) ? B_SUM : B_SORT;
					end
				end
				B_SORT: begin
					pass_q <= pass_q + 1'b1;
					if (pass_q == IDX_W'(BIN_DEPTH - 1)) begin
						if (op_q.cmd == CMD_MEDIAN) begin
							idx_q <= CNT_W'(op_q.n / MEDIAN_DIV);
							state_q <= B_PICK;
						end else begin
							idx_q <= lo;
							hi_q <= CNT_W'(lo * ROBUST_MUL);
							div_q <= CNT_W'(lo * (ROBUST_MUL - 1));
							sum_q <= '0;
							state_q <= B_SUM;
						end
					end
				end
				B_PICK: begin
					res_q <= scr_rd;
					state_q <= B_DONE;
				end
				B_SUM: begin
					sum_q <= sum_q + SUM_W'(scr_rd);
					idx_q <= idx_q + 1'b1;
					if ((idx_q + 1'b1) == hi_q) begin
						state_q <= B_ABS;
					end
				end
				B_ABS: begin
					neg_q <= sum_q[SUM_W-1];
					quo_q <= sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
					rem_q <= '0;
					step_q <= '0;
					state_q <= B_DIV;
				end
				B_DIV: begin
					// Restoring division, one quotient bit per cycle.
					if (rem_sh >= {1'b0, div_q}) begin
						rem_q <= CNT_W'(rem_sh - {1'b0, div_q});
						quo_q <= {quo_q[SUM_W-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh[CNT_W-1:0];
						quo_q <= {quo_q[SUM_W-2:0], 1'b0};
					end
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(SUM_W - 1)) begin
						state_q <= B_SGN;
					end
				end
				B_SGN: begin
					res_q <= neg_q ? -$signed(quo_q[SMP_W-1:0]) : $signed(quo_q[SMP_W-1:0]);
					state_q <= B_DONE;
				end
				B_DONE: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_valid_q <= 1'b1;
						rsp_q.result_value <= res_q;
						rsp_q.sample_count <= 5'(op_q.n);
						rsp_q.status <= op_q.status;
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

endmodule

/* rtl/core/binned_robust_averager.sv */
// Binned robust averager: per-bin mean, median and robust mean over a grid of bins.
// Depends on bra_pkg, bra_front, bra_queue, bra_back and the assertion macro header.
//
// After reset, and after every clear command, the block sweeps all NUM_BINS bin counts
// and takes no command meanwhile. A mean reads the bin's samples, one per cycle, sums
// them and divides with a one-bit-per-cycle divider. A median sorts the bin in BIN_DEPTH
// passes and needs no division, and a robust mean sorts the bin, sums a window of it and
// divides. The front takes a new command once it has pushed the last one into a two-entry
// queue, and classifies it while the back still works; a finished result waits in an
// output register.
module binned_robust_averager (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_ready,
	input bra_pkg::req_t req,
	output logic rsp_valid,
	input logic rsp_ready,
	output bra_pkg::rsp_t rsp
);
	import bra_pkg::*;

	`include "binned_robust_averager_assert.svh"

	logic q_push;
	logic q_pop;
	op_t op_f;
	op_t op_b;
	q_stat_t q_stat;

	// Command intake and count bookkeeping.
	bra_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.q_push(q_push),
		.q_op(op_f),
		.q_stat(q_stat)
	);

	// Decoupling queue.
	bra_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.op_in(op_f),
		.pop(q_pop),
		.op_out(op_b),
		.stat(q_stat)
	);

	// Sample storage and query arithmetic.
	bra_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_pop(q_pop),
		.q_op(op_b),
		.q_stat(q_stat),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	// The queue is never written when full nor read when empty.
	`BRA_ASSERT(a_q_no_overflow, !(q_push && q_stat.full), "queue written while full")
	`BRA_ASSERT(a_q_no_underflow, !(q_pop && q_stat.empty), "queue read while empty")
	// A result that is not ok carries a zero value.
	`BRA_IMPLY(a_bad_zero, rsp_valid && rsp.status != ST_OK, rsp.result_value == '0, "nonzero error")

endmodule

/* tb/binned_robust_averager_test.sv */
// Self-checking testbench for the binned robust averager: per-bin mean, median and robust mean.
// Depends on bra_pkg and the binned_robust_averager RTL; runs directed then random commands.
module binned_robust_averager_test;
	timeunit 1ns;
	timeprecision 1ps;
	import bra_pkg::*;

	localparam int STALL_LIMIT = 400000;
	localparam int CLEAR_SWEEP = 40000;
	localparam int HOT_BINS = 12;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	binned_robust_averager dut (
		.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req_ready(req_ready),
		.req(req), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	// Predictor state: sample memory and counts per bin.
	logic signed [23:0] bin_samples [NUM_BINS][BIN_DEPTH];
	int bin_fill [NUM_BINS];
	rsp_t expected_rsp [$];
	int fail_count = 0;
	int rsp_seen = 0;
	int items_sent;
	int idle_cycles = 0;
	bit rx_hold;
	bit idle_enable;
	logic [BIN_W-1:0] hot_bin [HOT_BINS];

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Works out the answer to one command and updates the predicted bin contents.
	function automatic rsp_t predict_answer(req_t r);
		rsp_t a;
		int b, n, lo, hi, i, j;
		longint sum;
		logic signed [23:0] srt [BIN_DEPTH];
		logic signed [23:0] v;
		b = {r.bin_x, r.bin_y, r.bin_z};
		n = bin_fill[b];
		a = '0;
		if (r.cmd == CMD_ADD) begin
			if (n >= BIN_DEPTH) a.status = ST_FULL;
			else begin
				bin_samples[b][n] = r.sample_value;
				n++;
				bin_fill[b] = n;
			end
		end else if (r.cmd == CMD_MEAN || r.cmd == CMD_MEDIAN || r.cmd == CMD_ROBUST) begin
			lo = (r.cmd == CMD_ROBUST) ? n / ROBUST_DIV : 0;
			hi = (r.cmd == CMD_ROBUST) ? lo * ROBUST_MUL : n;
			if (hi <= lo) a.status = ST_EMPTY;
			else begin
				for (i = 0; i < n; i++) srt[i] = bin_samples[b][i];
				// Insertion sort, ascending, only for the order-based queries.
				if (r.cmd != CMD_MEAN) begin
					for (i = 1; i < n; i++) begin
						v = srt[i];
						j = i;
						while (j > 0 && srt[j-1] > v) begin
							srt[j] = srt[j-1];
							j--;
						end
						srt[j] = v;
					end
				end
				if (r.cmd == CMD_MEDIAN) a.result_value = srt[n / MEDIAN_DIV];
				else begin
					sum = 0;
					for (i = lo; i < hi; i++) sum += longint'(srt[i]);
					a.result_value = 24'(sum / longint'(hi - lo));
				end
			end
		end else if (r.cmd == CMD_CLEAR) begin
			foreach (bin_fill[k]) bin_fill[k] = 0;
			n = 0;
		end
		a.sample_count = 5'(n);
		return a;
	endfunction

	task automatic wait_drained();
		req_valid <= 1'b0;
		while (expected_rsp.size() != 0) @(posedge clk);
	endtask

	// Sends one command: holds valid until the transfer, with random idle gaps.
	task automatic send_cmd(req_t r);
		while (idle_enable && $urandom_range(99) < 11) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		expected_rsp.push_back(predict_answer(r));
		items_sent++;
		if (r.cmd == CMD_CLEAR) begin
			req_valid <= 1'b0;
			wait_drained();
			repeat (CLEAR_SWEEP) @(posedge clk);
		end
	endtask

	function automatic req_t make_cmd(logic [2:0] c, logic [BIN_W-1:0] b, logic [23:0] s);
		req_t r;
		r.cmd = c;
		{r.bin_x, r.bin_y, r.bin_z} = b;
		r.sample_value = s;
		return r;
	endfunction

	// Receiver: random stalls, plus a long hold-off when requested.
	always @(posedge clk) begin
		if (!arst_n) rsp_ready <= 1'b0;
		else if (rx_hold) rsp_ready <= 1'b0;
		else rsp_ready <= !(idle_enable && $urandom_range(99) < 11);
	end

	// Checks every response transfer against the oldest prediction.
	always @(posedge clk) begin
		rsp_t e;
		if (arst_n && rsp_valid && rsp_ready) begin
			rsp_seen++;
			if (expected_rsp.size() == 0) begin
				$display("%0t unexpected response %h", $time, rsp);
				fail_count++;
			end else begin
				e = expected_rsp.pop_front();
				if (rsp.result_value !== e.result_value) begin
					$display("%0t result_value expected %0d actual %0d",
						$time, e.result_value, rsp.result_value);
					fail_count++;
				end
				if (rsp.sample_count !== e.sample_count) begin
					$display("%0t sample_count expected %0d actual %0d",
						$time, e.sample_count, rsp.sample_count);
					fail_count++;
				end
				if (rsp.status !== e.status) begin
					$display("%0t status expected %0d actual %0d",
						$time, e.status, rsp.status);
					fail_count++;
				end
			end
		end
	end

	// Watchdog over cycles with no transfer on either side.
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT) begin
			$display("Timeout waiting for a transfer.");
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Extremes, every command, full bin, empty bin, short robust window, unused codes, clear.
	task automatic test_directed();
		int i;
		logic [BIN_W-1:0] b;
		b = '1;
		send_cmd(make_cmd(CMD_MEAN, b, 24'h0));
		send_cmd(make_cmd(CMD_MEDIAN, b, 24'h0));
		send_cmd(make_cmd(CMD_ROBUST, b, 24'h0));
		send_cmd(make_cmd(CMD_ADD, b, 24'h7FFFFF));
		send_cmd(make_cmd(CMD_ADD, b, 24'h800000));
		send_cmd(make_cmd(CMD_ADD, b, 24'hFFFFFF));
		send_cmd(make_cmd(CMD_ROBUST, b, 24'h0));
		for (i = 0; i < 14; i++) send_cmd(make_cmd(CMD_ADD, b, (i & 1) ? 24'h7FFFFF : 24'h800000));
		send_cmd(make_cmd(CMD_MEAN, b, 24'h0));
		send_cmd(make_cmd(CMD_MEDIAN, b, 24'h0));
		send_cmd(make_cmd(CMD_ROBUST, b, 24'h0));
		send_cmd(make_cmd(3'd5, b, 24'h0));
		send_cmd(make_cmd(3'd7, '0, 24'h0));
		// A clear empties the bin, which then fills again from its first entry.
		send_cmd(make_cmd(CMD_CLEAR, b, 24'h0));
		send_cmd(make_cmd(CMD_MEAN, b, 24'h0));
		send_cmd(make_cmd(CMD_ADD, b, 24'h000100));
		send_cmd(make_cmd(CMD_MEDIAN, b, 24'h0));
		wait_drained();
	endtask

	// Random traffic, mostly concentrated on a few bins so they fill and sort deeply.
	task automatic test_random(int count);
		int i;
		req_t r;
		for (i = 0; i < count; i++) begin
			r = req_t'($bits(req_t)'({$urandom, $urandom}));
			if ($urandom_range(99) < 85)
				{r.bin_x, r.bin_y, r.bin_z} = hot_bin[$urandom_range(HOT_BINS-1)];
			case ($urandom_range(99)) inside
				[0:54]: r.cmd = CMD_ADD;
				[55:67]: r.cmd = CMD_MEAN;
				[68:80]: r.cmd = CMD_MEDIAN;
				[81:95]: r.cmd = CMD_ROBUST;
				[96:98]: r.cmd = 3'($urandom_range(5, 7));
				default: r.cmd = (i % 300 == 299) ? CMD_CLEAR : CMD_MEAN;
			endcase
			if ($urandom_range(9) == 0) r.sample_value = $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
			send_cmd(r);
		end
	endtask

	// Long receiver hold-off while the sender keeps offering, then a full drain pause.
	task automatic test_backpressure();
		int i;
		rx_hold = 1'b1;
		fork
			begin
				repeat (3000) @(posedge clk);
				rx_hold = 1'b0;
			end
			for (i = 0; i < 10; i++)
				send_cmd(make_cmd(CMD_ADD, hot_bin[0], 24'($urandom)));
		join
		wait_drained();
	endtask

	initial begin
		int i;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rx_hold = 1'b0;
		idle_enable = 1'b0;
		items_sent = 0;
		foreach (bin_fill[k]) bin_fill[k] = 0;
		for (i = 0; i < HOT_BINS; i++) hot_bin[i] = BIN_W'($urandom);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random(150);
		idle_enable = 1'b1;
		test_backpressure();
		test_random(950);
		wait_drained();
		repeat (200) @(posedge clk);
		$display("Sent %0d commands and checked %0d responses, with stalls and clears.",
			items_sent, rsp_seen);
		if (fail_count == 0 && expected_rsp.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
